[hw/rtl/paik_pkg.sv]
// Package for the planar arm inverse kinematics pipeline.
// Holds widths, constants, word and sideband types and the arctangent table.
// Depends on nothing; every module of the block imports it.
package paik_pkg;

   // Iterations of each vectoring CORDIC and size of the arctangent table.
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_ENTRIES  = 24;

   // Field widths.
   localparam int POS_W = 16;
   localparam int LEN_W = 15;
   localparam int ANG_W = 20;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_LINK  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_LINK = 1'b1;
   localparam logic [LEN_W-1:0] LINK_RESET = 15'd1600;

   // Restoring divider: one quotient bit per stage.
   localparam int DEN_W     = 32;
   localparam int REM_W     = DEN_W + 1;
   localparam int QUOT_W    = 31;
   localparam int DIV_STEPS = QUOT_W;

   // Square root: one root bit per stage.
   localparam int RAD_W      = 61;
   localparam int SQRT_W     = 62;
   localparam int ROOT_W     = 31;
   localparam int SQRT_STEPS = ROOT_W;

   // Cosine in Q2.30, CORDIC vectors and angles in radians with 28 fraction bits.
   localparam int COS_W = 32;
   localparam int CW    = 52;
   localparam int ZW    = 32;
   localparam int AW    = 36;
   localparam logic signed [COS_W-1:0] ONE_Q30     = 32'sh4000_0000;
   localparam logic signed [ZW-1:0]    PI_Q28      = 32'sd843314857;
   localparam logic signed [ZW-1:0]    HALF_PI_Q28 = 32'sd421657428;
   localparam logic [27:0]             DEG_FACTOR  = 28'd240315917;

   // How the elbow cosine is formed from the divider result.
   typedef enum logic [1:0] {
      COS_QUOTIENT,
      COS_PLUS_ONE,
      COS_MINUS_ONE,
      COS_ZERO
   } cos_sel_type;

   // Input and result words.
   typedef struct packed {
      logic signed [POS_W-1:0] target_x;
      logic signed [POS_W-1:0] target_y;
      logic signed [POS_W-1:0] target_orientation;
   } req_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] shoulder_angle;
      logic signed [ANG_W-1:0] elbow_angle;
      logic signed [ANG_W-1:0] wrist_angle;
      logic                    out_of_reach;
   } rsp_type;

   // Values that ride along the divider.
   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] phi;
      logic [LEN_W-1:0]        l1;
      logic [LEN_W-1:0]        l2;
      cos_sel_type             sel;
      logic                    neg;
      logic                    flag;
   } div_side_type;

   // Values that ride along the square root.
   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] phi;
      logic [LEN_W-1:0]        l1;
      logic [LEN_W-1:0]        l2;
      logic signed [COS_W-1:0] c;
      logic                    flag;
   } sqrt_side_type;

   // Arctangent of 2^-i in radians with 28 fraction bits.
   function automatic logic signed [ZW-1:0] atan_value(input int i);
      logic signed [ZW-1:0] v;
      case (i)
         0:  v = 32'sd210828714;
         1:  v = 32'sd124459457;
         2:  v = 32'sd65760959;
         3:  v = 32'sd33381290;
         4:  v = 32'sd16755422;
         5:  v = 32'sd8385879;
         6:  v = 32'sd4193963;
         7:  v = 32'sd2097109;
         8:  v = 32'sd1048571;
         9:  v = 32'sd524287;
         10: v = 32'sd262144;
         11: v = 32'sd131072;
         12: v = 32'sd65536;
         13: v = 32'sd32768;
         14: v = 32'sd16384;
         15: v = 32'sd8192;
         16: v = 32'sd4096;
         17: v = 32'sd2048;
         18: v = 32'sd1024;
         19: v = 32'sd512;
         20: v = 32'sd256;
         21: v = 32'sd128;
         22: v = 32'sd64;
         23: v = 32'sd32;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[hw/rtl/planar_arm_inverse_kinematics.sv]
// Two-link planar arm inverse kinematics: shoulder, elbow and wrist angles in degrees.
// Each word passes the input stages, the divider, the cosine stages, the square root,
// the vector stages, the CORDICs and the output stages; one word is taken every cycle unless stalled.
// A stall on the result side holds the whole pipeline in place.
// Synchronous reset clears all valid bits and sets both link lengths to 1600.
// Uses paik_pkg, paik_divider, paik_sqrt and paik_cordic.
module planar_arm_inverse_kinematics (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  paik_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output paik_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write,
   input  logic [paik_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [paik_pkg::LEN_W-1:0]        csr_wdata
);
   import paik_pkg::*;

   localparam int CSIDE_N = CORDIC_STAGES + 1;
   localparam logic [RAD_W-1:0] ONE_Q60 = RAD_W'(1) << 60;
   localparam logic signed [47:0] DEG_FACTOR_S = 48'sd240315917;
   localparam logic [63:0] ROUND_HALF = 64'(1) << 43;

   logic pipe_enable;

   logic [LEN_W-1:0] l1_ff;
   logic [LEN_W-1:0] l2_ff;

   // The pipeline moves unless a finished word is held at the output.
   assign pipe_enable = !(rsp_valid && rsp_stall);
   assign req_stall   = !pipe_enable;

   // Link length registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         l1_ff <= LINK_RESET;
         l2_ff <= LINK_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FIRST_LINK:  l1_ff <= csr_wdata;
            CSR_SECOND_LINK: l2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 1: capture the target and the link lengths.
   logic             s1_valid_ff;
   req_type          s1_req_ff;
   logic [LEN_W-1:0] s1_l1_ff;
   logic [LEN_W-1:0] s1_l2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pipe_enable) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         s1_req_ff <= req_data;
         s1_l1_ff  <= l1_ff;
         s1_l2_ff  <= l2_ff;
      end
   end

   // Stage 2: squares and the link product.
   logic signed [31:0] ext_x;
   logic signed [31:0] ext_y;
   logic signed [31:0] prod_x;
   logic signed [31:0] prod_y;
   logic        s2_valid_ff;
   req_type     s2_req_ff;
   logic [LEN_W-1:0] s2_l1_ff;
   logic [LEN_W-1:0] s2_l2_ff;
   logic [30:0] s2_sq_x_ff;
   logic [30:0] s2_sq_y_ff;
   logic [29:0] s2_sq_l1_ff;
   logic [29:0] s2_sq_l2_ff;
   logic [29:0] s2_l1l2_ff;

   always_comb begin
      ext_x  = 32'(s1_req_ff.target_x);
      ext_y  = 32'(s1_req_ff.target_y);
      prod_x = ext_x * ext_x;
      prod_y = ext_y * ext_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (pipe_enable) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         s2_req_ff   <= s1_req_ff;
         s2_l1_ff    <= s1_l1_ff;
         s2_l2_ff    <= s1_l2_ff;
         s2_sq_x_ff  <= prod_x[30:0];
         s2_sq_y_ff  <= prod_y[30:0];
         s2_sq_l1_ff <= 30'(s1_l1_ff) * 30'(s1_l1_ff);
         s2_sq_l2_ff <= 30'(s1_l2_ff) * 30'(s1_l2_ff);
         s2_l1l2_ff  <= 30'(s1_l1_ff) * 30'(s1_l2_ff);
      end
   end

   // Stage 3: numerator and denominator of the elbow cosine.
   logic [31:0]        sum_sq;
   logic [30:0]        len_sq;
   logic               s3_valid_ff;
   req_type            s3_req_ff;
   logic [LEN_W-1:0]   s3_l1_ff;
   logic [LEN_W-1:0]   s3_l2_ff;
   logic signed [33:0] s3_num_ff;
   logic [DEN_W-1:0]   s3_den_ff;

   always_comb begin
      sum_sq = {1'b0, s2_sq_x_ff} + {1'b0, s2_sq_y_ff};
      len_sq = {1'b0, s2_sq_l1_ff} + {1'b0, s2_sq_l2_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (pipe_enable) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         s3_req_ff <= s2_req_ff;
         s3_l1_ff  <= s2_l1_ff;
         s3_l2_ff  <= s2_l2_ff;
         s3_num_ff <= signed'({2'b00, sum_sq}) - signed'({3'b000, len_sq});
         s3_den_ff <= {1'b0, s2_l1l2_ff, 1'b0};
      end
   end

   // Stage 4: clamp decision and the magnitude handed to the divider.
   logic signed [33:0] den_s;
   logic [33:0]        num_neg;
   cos_sel_type        sel_in;
   logic [REM_W-1:0]   mag_in;
   logic               s4_valid_ff;
   logic [REM_W-1:0]   s4_mag_ff;
   logic [DEN_W-1:0]   s4_den_ff;
   div_side_type       s4_side_ff;

   always_comb begin
      den_s   = signed'({2'b00, s3_den_ff});
      num_neg = 34'(-s3_num_ff);
      mag_in  = '0;
      if (s3_num_ff > den_s) begin
         sel_in = COS_PLUS_ONE;
      end else if (s3_num_ff < -den_s) begin
         sel_in = COS_MINUS_ONE;
      end else if (s3_den_ff == '0) begin
         sel_in = COS_ZERO;
      end else begin
         sel_in = COS_QUOTIENT;
         mag_in = s3_num_ff[33] ? num_neg[REM_W-1:0] : s3_num_ff[REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (pipe_enable) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         s4_mag_ff       <= mag_in;
         s4_den_ff       <= s3_den_ff;
         s4_side_ff.x    <= s3_req_ff.target_x;
         s4_side_ff.y    <= s3_req_ff.target_y;
         s4_side_ff.phi  <= s3_req_ff.target_orientation;
         s4_side_ff.l1   <= s3_l1_ff;
         s4_side_ff.l2   <= s3_l2_ff;
         s4_side_ff.sel  <= sel_in;
         s4_side_ff.neg  <= s3_num_ff[33];
         s4_side_ff.flag <= (sel_in == COS_PLUS_ONE) || (sel_in == COS_MINUS_ONE);
      end
   end

   // Divider.
   logic              div_valid;
   logic [QUOT_W-1:0] div_quot;
   div_side_type      div_side;

   paik_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_enable),
      .in_valid  (s4_valid_ff),
      .in_mag    (s4_mag_ff),
      .in_den    (s4_den_ff),
      .in_side   (s4_side_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   // Stage 5: the signed, clamped cosine.
   logic signed [COS_W-1:0] quot_s;
   logic signed [COS_W-1:0] cos_in;
   logic          s5_valid_ff;
   sqrt_side_type s5_side_ff;

   always_comb begin
      quot_s = signed'({1'b0, div_quot});
      case (div_side.sel)
         COS_PLUS_ONE:  cos_in = ONE_Q30;
         COS_MINUS_ONE: cos_in = -ONE_Q30;
         COS_ZERO:      cos_in = '0;
         COS_QUOTIENT:  cos_in = div_side.neg ? -quot_s : quot_s;
         default:       cos_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (pipe_enable) begin
         s5_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         s5_side_ff.x    <= div_side.x;
         s5_side_ff.y    <= div_side.y;
         s5_side_ff.phi  <= div_side.phi;
         s5_side_ff.l1   <= div_side.l1;
         s5_side_ff.l2   <= div_side.l2;
         s5_side_ff.c    <= cos_in;
         s5_side_ff.flag <= div_side.flag;
      end
   end

   // Stage 6: square of the cosine.
   logic signed [63:0] cos_ext;
   logic signed [63:0] cos_sq;
   logic          s6_valid_ff;
   sqrt_side_type s6_side_ff;
   logic [RAD_W-1:0] s6_cos_sq_ff;

   always_comb begin
      cos_ext = 64'(s5_side_ff.c);
      cos_sq  = cos_ext * cos_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (pipe_enable) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         s6_side_ff   <= s5_side_ff;
         s6_cos_sq_ff <= cos_sq[RAD_W-1:0];
      end
   end

   // Stage 7: radicand one minus the squared cosine.
   logic             s7_valid_ff;
   sqrt_side_type    s7_side_ff;
   logic [RAD_W-1:0] s7_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (pipe_enable) begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         s7_side_ff <= s6_side_ff;
         s7_rad_ff  <= ONE_Q60 - s6_cos_sq_ff;
      end
   end

   // Square root gives the elbow sine.
   logic              sqrt_valid;
   logic [ROOT_W-1:0] sqrt_root;
   sqrt_side_type     sqrt_side;

   paik_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_enable),
      .in_valid  (s7_valid_ff),
      .in_value  (s7_rad_ff),
      .in_side   (s7_side_ff),
      .out_valid (sqrt_valid),
      .out_root  (sqrt_root),
      .out_side  (sqrt_side)
   );

   // Stage 8: second link times sine and cosine.
   logic signed [47:0] l2_ext;
   logic signed [47:0] c_ext;
   logic          s8_valid_ff;
   sqrt_side_type s8_side_ff;
   logic [ROOT_W-1:0]  s8_sin_ff;
   logic [45:0]        s8_l2s_ff;
   logic signed [47:0] s8_l2c_ff;

   always_comb begin
      l2_ext = signed'({33'd0, sqrt_side.l2});
      c_ext  = 48'(sqrt_side.c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else if (pipe_enable) begin
         s8_valid_ff <= sqrt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         s8_side_ff <= sqrt_side;
         s8_sin_ff  <= sqrt_root;
         s8_l2s_ff  <= 46'(sqrt_side.l2) * 46'(sqrt_root);
         s8_l2c_ff  <= l2_ext * c_ext;
      end
   end

   // Stage 9: the three vectors for the arctangents.
   logic                    s9_valid_ff;
   logic signed [POS_W-1:0] s9_phi_ff;
   logic                    s9_flag_ff;
   logic signed [CW-1:0]    s9_ax_ff;
   logic signed [CW-1:0]    s9_ay_ff;
   logic signed [CW-1:0]    s9_bx_ff;
   logic signed [CW-1:0]    s9_by_ff;
   logic signed [CW-1:0]    s9_cx_ff;
   logic signed [CW-1:0]    s9_cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else if (pipe_enable) begin
         s9_valid_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         s9_phi_ff  <= s8_side_ff.phi;
         s9_flag_ff <= s8_side_ff.flag;
         s9_ax_ff   <= CW'(s8_side_ff.c);
         s9_ay_ff   <= signed'(CW'(s8_sin_ff));
         s9_bx_ff   <= signed'({{6{s8_side_ff.x[POS_W-1]}}, s8_side_ff.x, 30'd0});
         s9_by_ff   <= signed'({{6{s8_side_ff.y[POS_W-1]}}, s8_side_ff.y, 30'd0});
         s9_cx_ff   <= signed'({7'd0, s8_side_ff.l1, 30'd0}) + CW'(s8_l2c_ff);
         s9_cy_ff   <= signed'(CW'(s8_l2s_ff));
      end
   end

   // Arctangents: elbow, target direction and the elbow offset.
   logic signed [ZW-1:0] z_elbow;
   logic signed [ZW-1:0] z_target;
   logic signed [ZW-1:0] z_offset;

   paik_cordic u_cordic_elbow (
      .clock  (clock),
      .enable (pipe_enable),
      .in_x   (s9_ax_ff),
      .in_y   (s9_ay_ff),
      .out_z  (z_elbow)
   );

   paik_cordic u_cordic_target (
      .clock  (clock),
      .enable (pipe_enable),
      .in_x   (s9_bx_ff),
      .in_y   (s9_by_ff),
      .out_z  (z_target)
   );

   paik_cordic u_cordic_offset (
      .clock  (clock),
      .enable (pipe_enable),
      .in_x   (s9_cx_ff),
      .in_y   (s9_cy_ff),
      .out_z  (z_offset)
   );

   // Valid, orientation and flag follow the CORDIC latency.
   logic                    cvalid_ff [CSIDE_N];
   logic signed [POS_W-1:0] cphi_ff   [CSIDE_N];
   logic                    cflag_ff  [CSIDE_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CSIDE_N; i++) begin
            cvalid_ff[i] <= 1'b0;
         end
      end else if (pipe_enable) begin
         cvalid_ff[0] <= s9_valid_ff;
         for (int i = 1; i < CSIDE_N; i++) begin
            cvalid_ff[i] <= cvalid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         cphi_ff[0]  <= s9_phi_ff;
         cflag_ff[0] <= s9_flag_ff;
         for (int i = 1; i < CSIDE_N; i++) begin
            cphi_ff[i]  <= cphi_ff[i-1];
            cflag_ff[i] <= cflag_ff[i-1];
         end
      end
   end

   // Stage 10: joint angles in radians (lanes: shoulder, elbow, wrist).
   logic signed [AW-1:0] shoulder_rad;
   logic signed [AW-1:0] elbow_rad;
   logic signed [AW-1:0] phi_rad;
   logic                 s10_valid_ff;
   logic                 s10_flag_ff;
   logic signed [AW-1:0] s10_angle_ff [3];

   always_comb begin
      shoulder_rad = AW'(z_target) - AW'(z_offset);
      elbow_rad    = AW'(z_elbow);
      phi_rad      = signed'({{4{cphi_ff[CSIDE_N-1][POS_W-1]}}, cphi_ff[CSIDE_N-1], 16'd0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_valid_ff <= 1'b0;
      end else if (pipe_enable) begin
         s10_valid_ff <= cvalid_ff[CSIDE_N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         s10_flag_ff     <= cflag_ff[CSIDE_N-1];
         s10_angle_ff[0] <= shoulder_rad;
         s10_angle_ff[1] <= elbow_rad;
         s10_angle_ff[2] <= phi_rad - shoulder_rad - elbow_rad;
      end
   end

   // Stage 11: partial products of the degree conversion; the upper part is signed.
   logic signed [47:0] hi_ext  [3];
   logic signed [47:0] hi_prod [3];
   logic               s11_valid_ff;
   logic               s11_flag_ff;
   logic signed [47:0] s11_hi_ff [3];
   logic [43:0]        s11_lo_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hi_ext[k]  = 48'(signed'(s10_angle_ff[k][AW-1:16]));
         hi_prod[k] = hi_ext[k] * DEG_FACTOR_S;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_valid_ff <= 1'b0;
      end else if (pipe_enable) begin
         s11_valid_ff <= s10_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         s11_flag_ff <= s10_flag_ff;
         for (int k = 0; k < 3; k++) begin
            s11_hi_ff[k] <= hi_prod[k];
            s11_lo_ff[k] <= 44'(s10_angle_ff[k][15:0]) * 44'(DEG_FACTOR);
         end
      end
   end

   // Stage 12: combine, round half up and keep the degree bits.
   logic [63:0] deg_sum [3];
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         deg_sum[k] = (64'(s11_hi_ff[k]) << 16) + 64'(s11_lo_ff[k]) + ROUND_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_enable) begin
         rsp_valid_ff <= s11_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         rsp_data_ff.shoulder_angle <= deg_sum[0][63:44];
         rsp_data_ff.elbow_angle    <= deg_sum[1][63:44];
         rsp_data_ff.wrist_angle    <= deg_sum[2][63:44];
         rsp_data_ff.out_of_reach   <= s11_flag_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/paik_divider.sv]
// Pipelined restoring divider for the elbow cosine, one quotient bit per stage.
// Carries the sideband word along with each quotient; uses paik_pkg.
module paik_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  logic [paik_pkg::REM_W-1:0]   in_mag,
   input  logic [paik_pkg::DEN_W-1:0]   in_den,
   input  paik_pkg::div_side_type       in_side,
   output logic                         out_valid,
   output logic [paik_pkg::QUOT_W-1:0]  out_quot,
   output paik_pkg::div_side_type       out_side
);
   import paik_pkg::*;

   logic              valid_ff [DIV_STEPS];
   logic [REM_W-1:0]  rem_ff   [DIV_STEPS];
   logic [DEN_W-1:0]  den_ff   [DIV_STEPS];
   logic [QUOT_W-1:0] quot_ff  [DIV_STEPS];
   div_side_type      side_ff  [DIV_STEPS];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      logic              prev_valid;
      logic [REM_W-1:0]  trial;
      logic [DEN_W-1:0]  prev_den;
      logic [QUOT_W-1:0] prev_quot;
      div_side_type      prev_side;
      logic [REM_W-1:0]  rem_in;
      logic [QUOT_W-1:0] quot_in;

      // The first stage tests the magnitude itself; later stages shift the remainder.
      if (j == 0) begin : g_head
         assign prev_valid = in_valid;
         assign trial      = in_mag;
         assign prev_den   = in_den;
         assign prev_quot  = '0;
         assign prev_side  = in_side;
      end else begin : g_tail
         assign prev_valid = valid_ff[j-1];
         assign trial      = {rem_ff[j-1][REM_W-2:0], 1'b0};
         assign prev_den   = den_ff[j-1];
         assign prev_quot  = quot_ff[j-1];
         assign prev_side  = side_ff[j-1];
      end

      // Compare and subtract, shifting the new bit into the quotient.
      always_comb begin
         if (trial >= {1'b0, prev_den}) begin
            rem_in  = trial - {1'b0, prev_den};
            quot_in = {prev_quot[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {prev_quot[QUOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (enable) begin
            valid_ff[j] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j]  <= rem_in;
            den_ff[j]  <= prev_den;
            quot_ff[j] <= quot_in;
            side_ff[j] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_quot  = quot_ff[DIV_STEPS-1];
   assign out_side  = side_ff[DIV_STEPS-1];

endmodule

[hw/rtl/paik_sqrt.sv]
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Gives the floor root of the radicand and carries the sideband word; uses paik_pkg.
module paik_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  logic [paik_pkg::RAD_W-1:0]   in_value,
   input  paik_pkg::sqrt_side_type      in_side,
   output logic                         out_valid,
   output logic [paik_pkg::ROOT_W-1:0]  out_root,
   output paik_pkg::sqrt_side_type      out_side
);
   import paik_pkg::*;

   logic              valid_ff [SQRT_STEPS];
   logic [SQRT_W-1:0] rest_ff  [SQRT_STEPS];
   logic [SQRT_W-1:0] root_ff  [SQRT_STEPS];
   sqrt_side_type     side_ff  [SQRT_STEPS];

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - j));

      logic              prev_valid;
      logic [SQRT_W-1:0] prev_rest;
      logic [SQRT_W-1:0] prev_root;
      sqrt_side_type     prev_side;
      logic [SQRT_W-1:0] trial;
      logic [SQRT_W-1:0] rest_in;
      logic [SQRT_W-1:0] root_in;

      if (j == 0) begin : g_head
         assign prev_valid = in_valid;
         assign prev_rest  = {1'b0, in_value};
         assign prev_root  = '0;
         assign prev_side  = in_side;
      end else begin : g_tail
         assign prev_valid = valid_ff[j-1];
         assign prev_rest  = rest_ff[j-1];
         assign prev_root  = root_ff[j-1];
         assign prev_side  = side_ff[j-1];
      end

      // Try this root bit; keep it when the remainder covers it.
      always_comb begin
         trial = prev_root + BIT;
         if (prev_rest >= trial) begin
            rest_in = prev_rest - trial;
            root_in = (prev_root >> 1) + BIT;
         end else begin
            rest_in = prev_rest;
            root_in = prev_root >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (enable) begin
            valid_ff[j] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rest_ff[j] <= rest_in;
            root_ff[j] <= root_in;
            side_ff[j] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS-1];
   assign out_root  = root_ff[SQRT_STEPS-1][ROOT_W-1:0];
   assign out_side  = side_ff[SQRT_STEPS-1];

endmodule

[hw/rtl/paik_cordic.sv]
// Pipelined vectoring CORDIC that gives atan2(y, x) in radians, 28 fraction bits.
// One pre-rotation stage, then one stage per iteration; uses paik_pkg.
module paik_cordic (
   input  logic                         clock,
   input  logic                         enable,
   input  logic signed [paik_pkg::CW-1:0] in_x,
   input  logic signed [paik_pkg::CW-1:0] in_y,
   output logic signed [paik_pkg::ZW-1:0] out_z
);
   import paik_pkg::*;

   logic signed [CW-1:0] x_ff [CORDIC_STAGES+1];
   logic signed [CW-1:0] y_ff [CORDIC_STAGES+1];
   logic signed [ZW-1:0] z_ff [CORDIC_STAGES+1];
   logic                 bypass_ff [CORDIC_STAGES+1];

   logic signed [CW-1:0] pre_x_in;
   logic signed [CW-1:0] pre_y_in;
   logic signed [ZW-1:0] pre_z_in;
   logic                 pre_bypass_in;

   // Vectors on an axis get their angle directly; the left half plane is
   // turned by a quarter turn into the right one.
   always_comb begin
      pre_x_in      = in_x;
      pre_y_in      = in_y;
      pre_z_in      = '0;
      pre_bypass_in = 1'b0;
      if (in_y == '0) begin
         pre_bypass_in = 1'b1;
         pre_z_in      = in_x[CW-1] ? PI_Q28 : '0;
      end else if (in_x == '0) begin
         pre_bypass_in = 1'b1;
         pre_z_in      = in_y[CW-1] ? -HALF_PI_Q28 : HALF_PI_Q28;
      end else if (in_x[CW-1]) begin
         if (!in_y[CW-1]) begin
            pre_z_in = HALF_PI_Q28;
            pre_x_in = in_y;
            pre_y_in = -in_x;
         end else begin
            pre_z_in = -HALF_PI_Q28;
            pre_x_in = -in_y;
            pre_y_in = in_x;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]      <= pre_x_in;
         y_ff[0]      <= pre_y_in;
         z_ff[0]      <= pre_z_in;
         bypass_ff[0] <= pre_bypass_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [CW-1:0] x_in;
      logic signed [CW-1:0] y_in;
      logic signed [ZW-1:0] z_in;

      // Rotate toward the x axis, direction set by the sign of y.
      always_comb begin
         dx = x_ff[i] >>> i;
         dy = y_ff[i] >>> i;
         x_in = x_ff[i];
         y_in = y_ff[i];
         z_in = z_ff[i];
         if (!bypass_ff[i]) begin
            if (!y_ff[i][CW-1]) begin
               x_in = x_ff[i] + dy;
               y_in = y_ff[i] - dx;
               z_in = z_ff[i] + atan_value(i);
            end else begin
               x_in = x_ff[i] - dy;
               y_in = y_ff[i] + dx;
               z_in = z_ff[i] - atan_value(i);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[i+1]      <= x_in;
            y_ff[i+1]      <= y_in;
            z_ff[i+1]      <= z_in;
            bypass_ff[i+1] <= bypass_ff[i];
         end
      end
   end

   assign out_z = z_ff[CORDIC_STAGES];

endmodule

[bench/paik_checker.sv]
// Checker for the planar arm inverse kinematics block: watches the three ports,
// predicts each result word from its own copy of the link lengths and compares.
// Depends on paik_pkg for the word types and the register indexes.
module paik_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  paik_pkg::req_type                req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  paik_pkg::rsp_type                rsp_data,
   input  logic                             csr_write,
   input  logic [paik_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [paik_pkg::LEN_W-1:0]       csr_wdata,
   output int                               fail_count,
   output int                               pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import paik_pkg::*;

   localparam longint UNIT_Q30 = longint'(1) << 30;

   logic [LEN_W-1:0] link_one;
   logic [LEN_W-1:0] link_two;
   rsp_type          joint_queue[$];
   int               word_count;

   initial begin
      fail_count = 0;
      word_count = 0;
   end

   assign pending = joint_queue.size();

   // Floor square root, one root bit per step.
   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Vectoring CORDIC arctangent in radians with 28 fraction bits.
   function automatic longint arc_tangent(input longint ya, input longint xa);
      longint z;
      longint t;
      longint dx;
      longint dy;
      z = 0;
      if (ya == 0) return (xa < 0) ? longint'(PI_Q28) : 0;
      if (xa == 0) return (ya > 0) ? longint'(HALF_PI_Q28) : -longint'(HALF_PI_Q28);
      // Rotate the left half plane into the right one first.
      if (xa < 0) begin
         if (ya > 0) begin
            z = longint'(HALF_PI_Q28);
            t = xa; xa = ya; ya = -t;
         end else begin
            z = -longint'(HALF_PI_Q28);
            t = xa; xa = -ya; ya = t;
         end
      end
      for (int i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
         dx = xa >>> i;
         dy = ya >>> i;
         if (ya >= 0) begin
            xa = xa + dy; ya = ya - dx; z = z + longint'(atan_value(i));
         end else begin
            xa = xa - dy; ya = ya + dx; z = z - longint'(atan_value(i));
         end
      end
      return z;
   endfunction

   // Radians to degrees with 6 fraction bits, rounded half up.
   function automatic logic signed [ANG_W-1:0] in_degrees(input longint rad);
      longint d;
      d = (rad * longint'(DEG_FACTOR) + (longint'(1) << 43)) >>> 44;
      return d[ANG_W-1:0];
   endfunction

   function automatic rsp_type solve_joints(input req_type w,
                                            input logic [LEN_W-1:0] la,
                                            input logic [LEN_W-1:0] lb);
      rsp_type         r;
      longint          x, y, phi, l1, l2, num, den, c, s, q1, q2, q3, q;
      longint unsigned mag;
      x   = longint'(w.target_x);
      y   = longint'(w.target_y);
      phi = longint'(w.target_orientation) * 65536;
      l1  = longint'(la);
      l2  = longint'(lb);
      num = x * x + y * y - l1 * l1 - l2 * l2;
      den = 2 * l1 * l2;
      r.out_of_reach = 1'b0;
      // Elbow cosine, clamped to the unit range.
      if (num > den) begin
         c = UNIT_Q30;
         r.out_of_reach = 1'b1;
      end else if (num < -den) begin
         c = -UNIT_Q30;
         r.out_of_reach = 1'b1;
      end else if (den == 0) begin
         c = 0;
      end else begin
         mag = (num < 0) ? -num : num;
         q = longint'((mag << 30) / longint'(den));
         c = (num < 0) ? -q : q;
      end
      s  = longint'(floor_root((longint'(1) << 60) - c * c));
      q2 = arc_tangent(s, c);
      q1 = arc_tangent(y * UNIT_Q30, x * UNIT_Q30) - arc_tangent(l2 * s, l1 * UNIT_Q30 + l2 * c);
      q3 = phi - q1 - q2;
      r.shoulder_angle = in_degrees(q1);
      r.elbow_angle    = in_degrees(q2);
      r.wrist_angle    = in_degrees(q3);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch word %0d %s: got %0d expected %0d", word_count, what, got, want);
      fail_count++;
   endtask

   // All three ports are sampled at the rising edge with their pre-edge values.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         link_one <= LINK_RESET;
         link_two <= LINK_RESET;
         joint_queue.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_FIRST_LINK) link_one <= csr_wdata;
            else if (csr_index == CSR_SECOND_LINK) link_two <= csr_wdata;
         end
         if (req_valid && !req_stall)
            joint_queue.push_back(solve_joints(req_data, link_one, link_two));
         if (rsp_valid && !rsp_stall) begin
            if (joint_queue.size() == 0) begin
               $display("result word %0d arrived with nothing expected", word_count);
               fail_count++;
            end else begin
               want = joint_queue.pop_front();
               if (rsp_data.shoulder_angle !== want.shoulder_angle)
                  report_mismatch("shoulder", longint'(rsp_data.shoulder_angle),
                                  longint'(want.shoulder_angle));
               if (rsp_data.elbow_angle !== want.elbow_angle)
                  report_mismatch("elbow", longint'(rsp_data.elbow_angle),
                                  longint'(want.elbow_angle));
               if (rsp_data.wrist_angle !== want.wrist_angle)
                  report_mismatch("wrist", longint'(rsp_data.wrist_angle),
                                  longint'(want.wrist_angle));
               if (rsp_data.out_of_reach !== want.out_of_reach)
                  report_mismatch("out_of_reach", longint'(rsp_data.out_of_reach),
                                  longint'(want.out_of_reach));
            end
            word_count++;
         end
      end
   end

endmodule

[bench/tb_top.sv]
// Top of the inverse kinematics testbench: clock, reset, target stimulus,
// result-side stalls and the verdict. Depends on paik_pkg, paik_checker and the block.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import paik_pkg::*;

   localparam int PHASES     = 8;
   localparam int PER_PHASE  = 230;
   localparam int DRAIN_WAIT = 100;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [LEN_W-1:0]       csr_wdata;
   int                     fail_count;
   int                     pending;

   logic                   req_fire = 1'b0;
   bit                     idle_on = 1'b1;
   bit                     hold_request = 1'b0;
   int                     reach;

   planar_arm_inverse_kinematics DUT (.*);

   paik_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

   // Remembers whether the last rising edge took a target word.
   always @(posedge clock) req_fire <= req_valid && !req_stall;

   // Result side: random stall bursts and one long hold when asked.
   initial begin
      int hold;
      int burst;
      hold  = 0;
      burst = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold = 400;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            burst = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_target(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] phi);
      req_valid <= 1'b1;
      req_data  <= '{target_x: x, target_y: y, target_orientation: phi};
      do @(negedge clock); while (!req_fire);
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic write_link(input logic [CSR_INDEX_W-1:0] index, input logic [LEN_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Waits until every expected result has come, then lets the pipeline empty.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // A target mostly inside a square a quarter wider than the reach, sometimes anywhere or on an axis.
   task automatic random_target();
      int lim;
      int pick;
      logic signed [15:0] x, y;
      lim  = reach + reach / 4 + 4;
      if (lim > 32767) lim = 32767;
      pick = $urandom_range(0, 9);
      x = 16'($urandom);
      y = 16'($urandom);
      if (pick < 6) begin
         x = 16'($urandom_range(0, 2 * lim) - lim);
         y = 16'($urandom_range(0, 2 * lim) - lim);
      end else if (pick == 6) begin
         x = 0;
      end else if (pick == 7) begin
         y = 0;
      end
      send_target(x, y, 16'($urandom));
   endtask

   initial begin
      int link_a[PHASES];
      int link_b[PHASES];
      link_a = '{1600, 1, 32767, 0, 1600, 0, 1000, 0};
      link_b = '{1600, 1, 32767, 1600, 0, 0, 3000, 0};
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_write = 1'b0;
      csr_index = CSR_FIRST_LINK;
      csr_wdata = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed targets at the reset link lengths (reach 3200).
      send_target(0, 0, 0);
      send_target(3200, 0, 0);
      send_target(3201, 0, 16'sh7fff);
      send_target(0, 3200, -16'sh8000);
      send_target(-3200, 0, 4096);
      send_target(0, -3200, -4096);
      send_target(-16'sh8000, -16'sh8000, -16'sh8000);
      send_target(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_target(-16'sh8000, 0, 0);
      send_target(0, 16'sh7fff, 0);
      send_target(0, -16'sh8000, 0);
      send_target(1000, -1000, 4096);
      send_target(-1000, 1000, -4096);
      send_target(-1000, -1000, 12868);
      send_target(1, 1, 1);
      send_target(-1, 0, -1);
      send_target(2262, 2262, 0);
      send_target(100, 50, 6434);
      drain_results();

      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) begin
            link_a[p] = $urandom_range(1, 32767);
            link_b[p] = $urandom_range(1, 32767);
            idle_on = 1'b0;
         end
         write_link(CSR_FIRST_LINK, LEN_W'(link_a[p]));
         write_link(CSR_SECOND_LINK, LEN_W'(link_b[p]));
         reach = link_a[p] + link_b[p];
         // Zero-length links: origin, a zero numerator and a far point.
         if (link_a[p] == 0 || link_b[p] == 0) begin
            send_target(0, 0, 0);
            send_target(16'(link_a[p] + link_b[p]), 0, 0);
            send_target(16'sh7fff, 0, 0);
         end
         if (p == 2) hold_request = 1'b1;
         for (int i = 0; i < PER_PHASE; i++) begin
            random_target();
            if (idle_on && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 3));
         end
         drain_results();
      end

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
